@@ rtl/core/fmse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmse_pkg
// Shared types, constants and tables of the two-operator fm synth engine.
// ----------------------------------------------------------------------------
package fmse_pkg;

  localparam int NUM_CHANNELS = 9;
  localparam int NUM_OPS      = 18;
  localparam int SINE_ENTRIES = 1024;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [21:0] MASTER_CLOCK      = 22'd3579545;
  localparam logic [16:0] SAMPLE_RATE_RESET = 17'd44100;
  localparam logic [14:0] FULL_SCALE        = 15'd32767;
  localparam logic [7:0]  ADDR_WAVE_EN      = 8'h01;

  localparam int DIV_DIVIDEND_W = 34;
  localparam int DIV_DIVISOR_W  = 25;
  localparam int DIV_CNT_W      = $clog2(DIV_DIVIDEND_W);

  typedef logic [4:0] op_idx_t;
  typedef logic [3:0] ch_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WAVE_EN,
    CMD_OP,
    CMD_CH
  } cmd_kind_t;

  typedef enum logic [2:0] {
    SUB_CHAR,
    SUB_LEVEL,
    SUB_AD,
    SUB_SR,
    SUB_WAVE,
    SUB_FNUM,
    SUB_KEY,
    SUB_FBCON
  } cmd_sub_t;

  typedef struct packed {
    cmd_kind_t  kind;
    cmd_sub_t   sub;
    op_idx_t    slot;
    ch_idx_t    chan;
    logic [7:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ENV_IDLE,
    ENV_ATTACK,
    ENV_DECAY,
    ENV_SUSTAIN,
    ENV_RELEASE
  } env_state_t;

  typedef struct packed {
    logic                      start;
    logic [DIV_DIVIDEND_W-1:0] dividend;
    logic [DIV_DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic [DIV_DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef logic signed [15:0] sine_tbl_t [SINE_ENTRIES];
  typedef logic [14:0]        amp_tbl_t [64];
  typedef logic [14:0]        sus_tbl_t [16];

  // rotation by about 1/1024 of a turn per entry, rounded each step
  function automatic sine_tbl_t gen_sine();
    sine_tbl_t t;
    int s, c, s2, c2;
    s = 0;
    c = 32767;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      s2 = (s * 32766 + c * 201 + 16383) / 32767;
      c2 = (c * 32766 - s * 201 + 16383) / 32767;
      t[i] = 16'(s);
      s = s2;
      c = c2;
    end
    return t;
  endfunction

  function automatic amp_tbl_t gen_amp();
    amp_tbl_t t;
    int oct, frac, hi, lo;
    for (int i = 0; i < 64; i++) begin
      oct  = i / 8;
      frac = i % 8;
      hi   = 32767 >> oct;
      lo   = 32767 >> (oct + 1);
      t[i] = (i >= 63) ? 15'd0 : 15'(hi - ((hi - lo) * frac) / 8);
    end
    return t;
  endfunction

  function automatic sus_tbl_t gen_sus();
    sus_tbl_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = 15'(((15 - i) * 32767) / 15);
    end
    return t;
  endfunction

  function automatic logic [4:0] mult_x2(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd0:  r = 5'd1;
      4'd1:  r = 5'd2;
      4'd2:  r = 5'd4;
      4'd3:  r = 5'd6;
      4'd4:  r = 5'd8;
      4'd5:  r = 5'd10;
      4'd6:  r = 5'd12;
      4'd7:  r = 5'd14;
      4'd8:  r = 5'd16;
      4'd9:  r = 5'd18;
      4'd10: r = 5'd20;
      4'd11: r = 5'd20;
      4'd12: r = 5'd24;
      4'd13: r = 5'd24;
      default: r = 5'd30;
    endcase
    return r;
  endfunction

  function automatic ch_idx_t chan_of_slot(input op_idx_t s);
    ch_idx_t c;
    unique case (s)
      5'd0, 5'd3:   c = 4'd0;
      5'd1, 5'd4:   c = 4'd1;
      5'd2, 5'd5:   c = 4'd2;
      5'd6, 5'd9:   c = 4'd3;
      5'd7, 5'd10:  c = 4'd4;
      5'd8, 5'd11:  c = 4'd5;
      5'd12, 5'd15: c = 4'd6;
      5'd13, 5'd16: c = 4'd7;
      default:      c = 4'd8;
    endcase
    return c;
  endfunction

  function automatic op_idx_t mod_of_chan(input ch_idx_t c);
    op_idx_t s;
    unique case (c)
      4'd0: s = 5'd0;
      4'd1: s = 5'd1;
      4'd2: s = 5'd2;
      4'd3: s = 5'd6;
      4'd4: s = 5'd7;
      4'd5: s = 5'd8;
      4'd6: s = 5'd12;
      4'd7: s = 5'd13;
      default: s = 5'd14;
    endcase
    return s;
  endfunction

  function automatic op_idx_t car_of_chan(input ch_idx_t c);
    return op_idx_t'(mod_of_chan(c) + 5'd3);
  endfunction

  // signed divide by 32767 toward zero, |x| below 2^30
  function automatic logic signed [15:0] div_fs(input logic signed [31:0] x);
    logic [31:0] neg;
    logic [30:0] mag;
    logic [15:0] q;
    logic [16:0] r;
    neg = 32'(-x);
    mag = x[31] ? neg[30:0] : x[30:0];
    q   = {1'b0, mag[29:15]};
    r   = {2'b00, mag[14:0]} + {1'b0, q};
    if (r >= 17'd32767) begin
      q = q + 16'd1;
    end
    return x[31] ? 16'(-$signed(q)) : $signed(q);
  endfunction

endpackage

@@ rtl/core/fmse_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmse_front
// Takes input words, decodes register addresses into commands and queues them.
// ----------------------------------------------------------------------------
module fmse_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [7:0]       reg_addr,
  input  logic [7:0]       reg_value,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output fmse_pkg::cmd_t   cmd
);

  fmse_pkg::cmd_t fifo [fmse_pkg::QUEUE_DEPTH];
  logic [fmse_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [fmse_pkg::QPTR_W:0]   count;

  fmse_pkg::cmd_t dec;
  logic           keep;
  logic [2:0]     grp;
  logic [4:0]     off5;
  logic           slot_ok;
  logic           push, pop;

  always_comb begin
    dec     = '0;
    keep    = 1'b0;
    slot_ok = 1'b0;
    grp     = reg_addr[7:5];
    off5    = reg_addr[4:0];
    dec.value = reg_value;
    if (off5 <= 5'd5) begin
      dec.slot = off5;
      slot_ok  = 1'b1;
    end else if (off5 >= 5'd8 && off5 <= 5'd13) begin
      dec.slot = off5 - 5'd2;
      slot_ok  = 1'b1;
    end else if (off5 >= 5'd16 && off5 <= 5'd21) begin
      dec.slot = off5 - 5'd4;
      slot_ok  = 1'b1;
    end
    dec.chan = reg_addr[3:0];
    if (mode) begin
      dec.kind = fmse_pkg::CMD_TICK;
      keep     = 1'b1;
    end else if (reg_addr == fmse_pkg::ADDR_WAVE_EN) begin
      dec.kind = fmse_pkg::CMD_WAVE_EN;
      keep     = 1'b1;
    end else if (grp inside {3'd1, 3'd2, 3'd3, 3'd4, 3'd7}) begin
      dec.kind = fmse_pkg::CMD_OP;
      unique case (grp)
        3'd1:    dec.sub = fmse_pkg::SUB_CHAR;
        3'd2:    dec.sub = fmse_pkg::SUB_LEVEL;
        3'd3:    dec.sub = fmse_pkg::SUB_AD;
        3'd4:    dec.sub = fmse_pkg::SUB_SR;
        default: dec.sub = fmse_pkg::SUB_WAVE;
      endcase
      keep = slot_ok &&
             (fmse_pkg::chan_of_slot(dec.slot) < 4'(fmse_pkg::NUM_CHANNELS));
    end else begin
      dec.kind = fmse_pkg::CMD_CH;
      keep     = reg_addr[3:0] < 4'(fmse_pkg::NUM_CHANNELS);
      unique case (reg_addr[7:4])
        4'hA:    dec.sub = fmse_pkg::SUB_FNUM;
        4'hB:    dec.sub = fmse_pkg::SUB_KEY;
        4'hC:    dec.sub = fmse_pkg::SUB_FBCON;
        default: keep = 1'b0;
      endcase
    end
  end

  assign in_ready  = count != (fmse_pkg::QPTR_W + 1)'(fmse_pkg::QUEUE_DEPTH);
  assign cmd_valid = count != '0;
  assign cmd       = fifo[rd_ptr];
  // unmapped writes are taken and dropped here
  assign push = in_valid && in_ready && keep;
  assign pop  = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        fifo[wr_ptr] <= dec;
        wr_ptr       <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/fmse_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmse_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmse_div (
  input  logic               clk,
  input  logic               rst,
  input  fmse_pkg::div_req_t req,
  output fmse_pkg::div_rsp_t rsp
);

  logic                                busy, done;
  logic [fmse_pkg::DIV_CNT_W-1:0]      cnt;
  logic [fmse_pkg::DIV_DIVISOR_W-1:0]  rem, dsr;
  logic [fmse_pkg::DIV_DIVIDEND_W-1:0] quo;
  logic [fmse_pkg::DIV_DIVISOR_W:0]    trial;
  logic                                fits;

  assign trial = {rem, quo[fmse_pkg::DIV_DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? fmse_pkg::DIV_DIVISOR_W'(trial - {1'b0, dsr})
                    : trial[fmse_pkg::DIV_DIVISOR_W-1:0];
        quo <= {quo[fmse_pkg::DIV_DIVIDEND_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == fmse_pkg::DIV_CNT_W'(fmse_pkg::DIV_DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/fmse_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmse_back
// Sequencer that carries out register writes and walks the operators per tick.
// ----------------------------------------------------------------------------
module fmse_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [16:0]               cfg_wdata,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  fmse_pkg::cmd_t            cmd,
  output fmse_pkg::div_req_t        div_req,
  input  fmse_pkg::div_rsp_t        div_rsp,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        sample
);

  localparam int NOPS = fmse_pkg::NUM_OPS;
  localparam int NCH  = fmse_pkg::NUM_CHANNELS;
  localparam fmse_pkg::sine_tbl_t SINE = fmse_pkg::gen_sine();
  localparam fmse_pkg::amp_tbl_t  AMP  = fmse_pkg::gen_amp();
  localparam fmse_pkg::sus_tbl_t  SUS  = fmse_pkg::gen_sus();

  typedef enum logic [4:0] {
    S_IDLE, S_WDEC, S_PH_A, S_PH_B, S_PH_DIV, S_PH_WAIT, S_EN_DIV, S_EN_WAIT,
    S_KEY, S_T_CHK0, S_T_CHK1, S_T_CHK2, S_OP_ENV, S_OP_ADDR, S_OP_ROM,
    S_OP_MUL1, S_OP_MUL2, S_OP_DONE, S_T_FIN
  } state_t;

  state_t state;

  logic [16:0] sample_rate;
  logic        wave_en;

  // operator state
  logic                 op_eg    [NOPS];
  logic [3:0]           op_mult  [NOPS];
  logic [5:0]           op_tl    [NOPS];
  logic [3:0]           op_ar    [NOPS];
  logic [3:0]           op_dr    [NOPS];
  logic [3:0]           op_rr    [NOPS];
  logic [1:0]           op_ws    [NOPS];
  logic [9:0]           op_phase [NOPS];
  logic [9:0]           op_step  [NOPS];
  logic [14:0]          op_level [NOPS];
  fmse_pkg::env_state_t op_est   [NOPS];
  logic [14:0]          op_astep [NOPS];
  logic [14:0]          op_dstep [NOPS];
  logic [14:0]          op_rstep [NOPS];
  logic [14:0]          op_sus   [NOPS];
  logic signed [15:0]   op_last  [NOPS];

  // channel state
  logic [9:0] ch_fnum  [NCH];
  logic [2:0] ch_block [NCH];
  logic       ch_key   [NCH];
  logic [2:0] ch_fb    [NCH];
  logic       ch_con   [NCH];

  fmse_pkg::cmd_t     cmd_r;
  fmse_pkg::op_idx_t  op;
  fmse_pkg::ch_idx_t  ch;
  logic [1:0]         k;
  logic               key_on_edge, key_off_edge;
  logic               is_car, mod_idle;
  logic [31:0]        ph_a;
  logic [36:0]        ph_b;
  logic [14:0]        env_r;
  logic [9:0]         rom_addr;
  logic               rom_zero;
  logic signed [15:0] rom_q;
  logic signed [31:0] prod;
  logic signed [15:0] mod_out_r;
  logic signed [19:0] acc;

  // combinational helpers
  logic [16:0]          srate_eff;
  fmse_pkg::ch_idx_t    cc;
  logic                 last_ch;
  logic [3:0]           rsel;
  logic [3:0]           rsh;
  logic [33:0]          env_num;
  logic [14:0]          env_step;
  logic [33:0]          ph_div;
  logic signed [16:0]   lv, lv_sum;
  logic [14:0]          lv_next;
  fmse_pkg::env_state_t est_next;
  logic signed [15:0]   mod_in;
  logic [9:0]           idx;
  logic [9:0]           addr_next;
  logic                 zero_next;
  logic signed [15:0]   op_out;
  logic signed [16:0]   pair_sum;
  logic signed [15:0]   ch_val;
  logic signed [19:0]   acc_adj, acc_q;
  logic signed [15:0]   fin_val;

  assign cmd_ready = state == S_IDLE;
  assign srate_eff = (sample_rate == '0) ? 17'd1 : sample_rate;
  assign cc        = (cmd_r.kind == fmse_pkg::CMD_OP) ?
                     fmse_pkg::chan_of_slot(cmd_r.slot) : cmd_r.chan;
  assign last_ch   = ch == fmse_pkg::ch_idx_t'(NCH - 1);

  // envelope rate division
  always_comb begin
    unique case (k)
      2'd0:    rsel = op_ar[op];
      2'd1:    rsel = op_dr[op];
      default: rsel = op_rr[op];
    endcase
    rsh     = (rsel > 4'd1) ? rsel - 4'd1 : 4'd0;
    env_num = ((k == 2'd0) ? 34'd262136 : 34'd32767) << rsh;
    if (rsel == 4'd0) begin
      env_step = '0;
    end else if (rsel == 4'd15) begin
      env_step = fmse_pkg::FULL_SCALE;
    end else if (div_rsp.quotient == '0) begin
      env_step = 15'd1;
    end else if (div_rsp.quotient > 34'd32767) begin
      env_step = fmse_pkg::FULL_SCALE;
    end else begin
      env_step = div_rsp.quotient[14:0];
    end
  end

  assign ph_div = 34'(ph_b >> (4'd10 - {1'b0, ch_block[ch]}));

  always_comb begin
    div_req.start    = (state == S_PH_DIV) || (state == S_EN_DIV);
    if (state == S_PH_DIV) begin
      div_req.dividend = ph_div;
      div_req.divisor  = 25'(srate_eff) * 25'd144;
    end else begin
      div_req.dividend = env_num;
      div_req.divisor  = 25'(srate_eff);
    end
  end

  // envelope step of the current operator
  always_comb begin
    lv       = {2'b00, op_level[op]};
    lv_sum   = lv;
    lv_next  = op_level[op];
    est_next = op_est[op];
    unique case (op_est[op])
      fmse_pkg::ENV_ATTACK: begin
        lv_sum = lv + {2'b00, op_astep[op]};
        if (op_astep[op] == fmse_pkg::FULL_SCALE || lv_sum >= 17'sd32767) begin
          lv_next  = fmse_pkg::FULL_SCALE;
          est_next = fmse_pkg::ENV_DECAY;
        end else begin
          lv_next = lv_sum[14:0];
        end
      end
      fmse_pkg::ENV_DECAY: begin
        lv_sum = lv - {2'b00, op_dstep[op]};
        if (op_dstep[op] == '0) begin
          est_next = fmse_pkg::ENV_SUSTAIN;
        end else if (lv_sum <= $signed({2'b00, op_sus[op]})) begin
          lv_next  = op_sus[op];
          est_next = op_eg[op] ? fmse_pkg::ENV_SUSTAIN : fmse_pkg::ENV_RELEASE;
        end else begin
          lv_next = lv_sum[14:0];
        end
      end
      fmse_pkg::ENV_RELEASE: begin
        lv_sum = lv - {2'b00, op_rstep[op]};
        if (op_rstep[op] != '0) begin
          if (lv_sum <= 17'sd0) begin
            lv_next  = '0;
            est_next = fmse_pkg::ENV_IDLE;
          end else begin
            lv_next = lv_sum[14:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // waveform address with feedback or modulation
  always_comb begin
    if (is_car) begin
      mod_in = ch_con[ch] ? 16'sd0 : mod_out_r;
    end else if (ch_fb[ch] != 3'd0) begin
      mod_in = op_last[op] >>> (4'd9 - {1'b0, ch_fb[ch]});
    end else begin
      mod_in = 16'sd0;
    end
    idx = op_phase[op] + mod_in[14:5];
    unique case (op_ws[op])
      2'd0: begin
        addr_next = idx;
        zero_next = 1'b0;
      end
      2'd1: begin
        addr_next = idx;
        zero_next = idx[9];
      end
      2'd2: begin
        addr_next = idx[9] ? ~idx : idx;
        zero_next = 1'b0;
      end
      default: begin
        addr_next = {1'b0, idx[7:0], 1'b0};
        zero_next = idx[8];
      end
    endcase
  end

  always_comb begin
    op_out   = fmse_pkg::div_fs(prod);
    pair_sum = {op_out[15], op_out} + {mod_out_r[15], mod_out_r};
    if (!ch_con[ch]) begin
      ch_val = op_out;
    end else if (pair_sum > 17'sd32767) begin
      ch_val = 16'sd32767;
    end else if (pair_sum < -17'sd32767) begin
      ch_val = -16'sd32767;
    end else begin
      ch_val = pair_sum[15:0];
    end
    acc_adj = acc + (acc[19] ? 20'sd3 : 20'sd0);
    acc_q   = acc_adj >>> 2;
    if (acc_q > 20'sd32767) begin
      fin_val = 16'sd32767;
    end else if (acc_q < -20'sd32767) begin
      fin_val = -16'sd32767;
    end else begin
      fin_val = acc_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      sample_rate  <= fmse_pkg::SAMPLE_RATE_RESET;
      wave_en      <= 1'b0;
      op           <= '0;
      ch           <= '0;
      k            <= '0;
      is_car       <= 1'b0;
      key_on_edge  <= 1'b0;
      key_off_edge <= 1'b0;
      for (int i = 0; i < NOPS; i++) begin
        op_eg[i]    <= 1'b0;
        op_mult[i]  <= '0;
        op_tl[i]    <= '0;
        op_ar[i]    <= '0;
        op_dr[i]    <= '0;
        op_rr[i]    <= '0;
        op_ws[i]    <= '0;
        op_phase[i] <= '0;
        op_step[i]  <= '0;
        op_level[i] <= '0;
        op_est[i]   <= fmse_pkg::ENV_IDLE;
        op_astep[i] <= '0;
        op_dstep[i] <= '0;
        op_rstep[i] <= '0;
        op_sus[i]   <= fmse_pkg::FULL_SCALE;
        op_last[i]  <= '0;
      end
      for (int i = 0; i < NCH; i++) begin
        ch_fnum[i]  <= '0;
        ch_block[i] <= '0;
        ch_key[i]   <= 1'b0;
        ch_fb[i]    <= '0;
        ch_con[i]   <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        sample_rate <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            if (cmd.kind == fmse_pkg::CMD_TICK) begin
              ch    <= '0;
              acc   <= '0;
              state <= S_T_CHK0;
            end else begin
              state <= S_WDEC;
            end
          end
        end
        S_WDEC: begin
          ch           <= cc;
          op           <= fmse_pkg::mod_of_chan(cc);
          k            <= '0;
          key_on_edge  <= 1'b0;
          key_off_edge <= 1'b0;
          state        <= S_IDLE;
          unique case (cmd_r.kind)
            fmse_pkg::CMD_WAVE_EN: wave_en <= cmd_r.value[5];
            fmse_pkg::CMD_OP: begin
              unique case (cmd_r.sub)
                fmse_pkg::SUB_CHAR: begin
                  op_eg[cmd_r.slot]   <= cmd_r.value[5];
                  op_mult[cmd_r.slot] <= cmd_r.value[3:0];
                  state               <= S_PH_A;
                end
                fmse_pkg::SUB_LEVEL: op_tl[cmd_r.slot] <= cmd_r.value[5:0];
                fmse_pkg::SUB_AD: begin
                  op_ar[cmd_r.slot] <= cmd_r.value[7:4];
                  op_dr[cmd_r.slot] <= cmd_r.value[3:0];
                  op                <= cmd_r.slot;
                  state             <= S_EN_DIV;
                end
                fmse_pkg::SUB_SR: begin
                  op_sus[cmd_r.slot] <= SUS[cmd_r.value[7:4]];
                  op_rr[cmd_r.slot]  <= cmd_r.value[3:0];
                  op                 <= cmd_r.slot;
                  state              <= S_EN_DIV;
                end
                default: op_ws[cmd_r.slot] <= wave_en ? cmd_r.value[1:0] : 2'd0;
              endcase
            end
            default: begin
              unique case (cmd_r.sub)
                fmse_pkg::SUB_FNUM: begin
                  ch_fnum[cmd_r.chan][7:0] <= cmd_r.value;
                  state                    <= S_PH_A;
                end
                fmse_pkg::SUB_KEY: begin
                  ch_key[cmd_r.chan]       <= cmd_r.value[5];
                  ch_block[cmd_r.chan]     <= cmd_r.value[4:2];
                  ch_fnum[cmd_r.chan][9:8] <= cmd_r.value[1:0];
                  key_on_edge  <= !ch_key[cmd_r.chan] && cmd_r.value[5];
                  key_off_edge <= ch_key[cmd_r.chan] && !cmd_r.value[5];
                  state        <= S_PH_A;
                end
                default: begin
                  ch_fb[cmd_r.chan]  <= cmd_r.value[3:1];
                  ch_con[cmd_r.chan] <= cmd_r.value[0];
                end
              endcase
            end
          endcase
        end
        S_PH_A: begin
          ph_a  <= 32'(ch_fnum[ch]) * 32'(fmse_pkg::MASTER_CLOCK);
          state <= S_PH_B;
        end
        S_PH_B: begin
          ph_b  <= 37'({5'd0, ph_a} * {32'd0, fmse_pkg::mult_x2(op_mult[op])});
          state <= S_PH_DIV;
        end
        S_PH_DIV: state <= S_PH_WAIT;
        S_PH_WAIT: begin
          if (div_rsp.done) begin
            op_step[op] <= div_rsp.quotient[9:0];
            if (k == 2'd0) begin
              k     <= 2'd1;
              op    <= fmse_pkg::car_of_chan(ch);
              state <= S_PH_A;
            end else if (key_on_edge || key_off_edge) begin
              k     <= 2'd0;
              op    <= fmse_pkg::mod_of_chan(ch);
              state <= S_KEY;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EN_DIV: state <= S_EN_WAIT;
        S_EN_WAIT: begin
          if (div_rsp.done) begin
            unique case (k)
              2'd0:    op_astep[op] <= env_step;
              2'd1:    op_dstep[op] <= env_step;
              default: op_rstep[op] <= env_step;
            endcase
            if (k == 2'd2) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 2'd1;
              state <= S_EN_DIV;
            end
          end
        end
        S_KEY: begin
          if (key_on_edge) begin
            op_phase[op] <= '0;
            op_est[op]   <= fmse_pkg::ENV_ATTACK;
            op_level[op] <= '0;
            op_last[op]  <= '0;
          end else if (op_est[op] != fmse_pkg::ENV_IDLE) begin
            op_est[op] <= fmse_pkg::ENV_RELEASE;
          end
          if (k == 2'd0) begin
            k  <= 2'd1;
            op <= fmse_pkg::car_of_chan(ch);
          end else begin
            state <= S_IDLE;
          end
        end
        S_T_CHK0: begin
          op    <= fmse_pkg::mod_of_chan(ch);
          state <= S_T_CHK1;
        end
        S_T_CHK1: begin
          mod_idle <= op_est[op] == fmse_pkg::ENV_IDLE;
          op       <= fmse_pkg::car_of_chan(ch);
          state    <= S_T_CHK2;
        end
        S_T_CHK2: begin
          if (mod_idle && op_est[op] == fmse_pkg::ENV_IDLE) begin
            if (last_ch) begin
              state <= S_T_FIN;
            end else begin
              ch    <= ch + 4'd1;
              state <= S_T_CHK0;
            end
          end else begin
            op     <= fmse_pkg::mod_of_chan(ch);
            is_car <= 1'b0;
            state  <= S_OP_ENV;
          end
        end
        S_OP_ENV: begin
          op_level[op] <= lv_next;
          op_est[op]   <= est_next;
          env_r        <= lv_next;
          state        <= S_OP_ADDR;
        end
        S_OP_ADDR: begin
          rom_addr     <= addr_next;
          rom_zero     <= zero_next;
          op_phase[op] <= op_phase[op] + op_step[op];
          state        <= S_OP_ROM;
        end
        // sine word lands in rom_q during this cycle
        S_OP_ROM: state <= S_OP_MUL1;
        S_OP_MUL1: begin
          prod  <= (rom_zero ? 16'sd0 : rom_q) * $signed({1'b0, env_r});
          state <= S_OP_MUL2;
        end
        S_OP_MUL2: begin
          prod  <= fmse_pkg::div_fs(prod) * $signed({1'b0, AMP[op_tl[op]]});
          state <= S_OP_DONE;
        end
        S_OP_DONE: begin
          if (!is_car) begin
            op_last[op] <= op_out;
            mod_out_r   <= op_out;
            is_car      <= 1'b1;
            op          <= fmse_pkg::car_of_chan(ch);
            state       <= S_OP_ENV;
          end else begin
            acc <= acc + {{4{ch_val[15]}}, ch_val};
            if (last_ch) begin
              state <= S_T_FIN;
            end else begin
              ch    <= ch + 4'd1;
              state <= S_T_CHK0;
            end
          end
        end
        S_T_FIN: begin
          if (!out_valid || out_ready) begin
            sample    <= fin_val;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_PH_WAIT || state == S_EN_WAIT))
    else $error("quotient arrived with no one waiting");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample != 16'sh8000)
    else $error("sample outside clamp range");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_T_FIN && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished tick did not reach the output register");
`endif

endmodule

@@ rtl/core/fm_synth_register_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_synth_register_engine
// Nine-channel two-operator fm synthesizer driven by register and tick words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): mode 0 writes reg_value to reg_addr,
// mode 1 is a sample tick. Each tick word yields one sample word on the
// output channel (out_valid/out_ready); writes yield nothing.
// cfg_we/cfg_wdata load sample_rate; write it only while the engine is idle.
// Input words pass through a four-entry command queue, so the input keeps
// flowing while the back end works or the output register waits.
// A tick walks the channels one operator at a time, modulator then carrier,
// and skips a channel whose two operators are both idle. Frequency, key and
// characteristic writes run two divisions on the serial divider, envelope
// writes three; other writes return to idle directly. Reset (synchronous
// rst) silences every operator, resets the operator and channel registers
// and sets sample_rate to 44100. If out_ready stays low the finished sample
// holds in the output register, the next tick waits behind it and the queue
// fills.
// ----------------------------------------------------------------------------
module fm_synth_register_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [7:0]         reg_addr,
  input  logic [7:0]         reg_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_wdata
);

  fmse_pkg::cmd_t     cmd;
  logic               cmd_valid, cmd_ready;
  fmse_pkg::div_req_t div_req;
  fmse_pkg::div_rsp_t div_rsp;

  fmse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .reg_addr  (reg_addr),
    .reg_value (reg_value),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fmse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fmse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
  );

endmodule

@@ dv/fm_synth_register_engine_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_synth_register_engine_chk
// Watches the fm synth channels, keeps a shadow of the engine and checks
// every sample word against the shadow's prediction for each tick word.
// ----------------------------------------------------------------------------
module fm_synth_register_engine_chk
  import fmse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               mode,
  input  logic [7:0]         reg_addr,
  input  logic [7:0]         reg_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] sample,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_wdata,
  output int                 fail_count,
  output int                 samples_owed
);

  localparam logic [7:0] BANK_CHAR  = 8'h20;
  localparam logic [7:0] BANK_LEVEL = 8'h40;
  localparam logic [7:0] BANK_AD    = 8'h60;
  localparam logic [7:0] BANK_SR    = 8'h80;
  localparam logic [7:0] BANK_WAVE  = 8'hE0;
  localparam logic [7:0] REG_FNUM   = 8'hA0;
  localparam logic [7:0] REG_KEY    = 8'hB0;
  localparam logic [7:0] REG_FBCON  = 8'hC0;
  localparam int         FS         = 32767;

  localparam int MULX2 [16] = '{1, 2, 4, 6, 8, 10, 12, 14, 16, 18, 20, 20, 24, 24, 30, 30};
  localparam int SLOT_CH [18] = '{0, 1, 2, 0, 1, 2, 3, 4, 5, 3, 4, 5, 6, 7, 8, 6, 7, 8};
  localparam int CH_MOD [9] = '{0, 1, 2, 6, 7, 8, 12, 13, 14};

  int unsigned rate;
  int          sine_tbl [SINE_ENTRIES];
  logic [31:0] ph [18];
  logic [31:0] ph_step [18];
  int          lvl [18];
  env_state_t  est [18];
  int          atk [18];
  int          dcy [18];
  int          rel [18];
  int          sus [18];
  int          last_out [18];
  logic [3:0]  o_mul [18];
  logic [5:0]  o_tl [18];
  logic [3:0]  o_ar [18];
  logic [3:0]  o_dr [18];
  logic [3:0]  o_sl [18];
  logic [3:0]  o_rr [18];
  logic [1:0]  o_ws [18];
  logic        o_eg [18];
  logic [9:0]  c_fnum [9];
  logic [2:0]  c_blk [9];
  logic        c_key [9];
  logic [2:0]  c_fb [9];
  logic        c_con [9];
  logic        wave_en;
  int          owed_samples [$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic longint unsigned rate_div();
    return (rate == 0) ? 64'd1 : longint'(rate);
  endfunction

  function automatic int tl_amp(input int t);
    int hi, lo;
    if (t >= 63) return 0;
    hi = FS >> (t / 8);
    lo = FS >> (t / 8 + 1);
    return hi - ((hi - lo) * (t % 8)) / 8;
  endfunction

  function automatic int env_step(input int r, input int base);
    longint unsigned n;
    if (r == 0) return 0;
    if (r >= 15) return FS;
    n = 64'd32767 * base;
    if (r > 1) n = n << (r - 1);
    n = n / rate_div();
    if (n < 1) return 1;
    if (n > 32767) return FS;
    return int'(n);
  endfunction

  function automatic logic [31:0] phase_inc(input int c, input int s);
    longint unsigned num, den, q;
    num = longint'(c_fnum[c]) * 64'd3579545 * 64'd1024 * MULX2[o_mul[s]];
    den = 64'd144 * (64'd1 << (20 - c_blk[c])) * rate_div();
    q   = num / den;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    q = q << 22;
    return q[31:0];
  endfunction

  task automatic refresh_env(input int s);
    atk[s] = env_step(o_ar[s], 8);
    dcy[s] = env_step(o_dr[s], 1);
    rel[s] = env_step(o_rr[s], 1);
    sus[s] = ((15 - o_sl[s]) * FS) / 15;
  endtask

  task automatic refresh_phase(input int c);
    ph_step[CH_MOD[c]]     = phase_inc(c, CH_MOD[c]);
    ph_step[CH_MOD[c] + 3] = phase_inc(c, CH_MOD[c] + 3);
  endtask

  task automatic shadow_reset();
    int s, c, s2, c2;
    rate = SAMPLE_RATE_RESET;
    s = 0;
    c = FS;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      s2 = (s * 32766 + c * 201 + 16383) / FS;
      c2 = (c * 32766 - s * 201 + 16383) / FS;
      sine_tbl[i] = s;
      s = s2;
      c = c2;
    end
    for (int i = 0; i < 18; i++) begin
      ph[i] = '0; ph_step[i] = '0; lvl[i] = 0; est[i] = ENV_IDLE;
      atk[i] = 0; dcy[i] = 0; rel[i] = 0; sus[i] = FS; last_out[i] = 0;
      o_mul[i] = '0; o_tl[i] = '0; o_ar[i] = '0; o_dr[i] = '0;
      o_sl[i] = '0; o_rr[i] = '0; o_ws[i] = '0; o_eg[i] = 1'b0;
    end
    for (int i = 0; i < 9; i++) begin
      c_fnum[i] = '0; c_blk[i] = '0; c_key[i] = 1'b0; c_fb[i] = '0; c_con[i] = 1'b0;
    end
    wave_en = 1'b0;
  endtask

  task automatic apply_write(input logic [7:0] a, input logic [7:0] v);
    logic [7:0] grp;
    int off, s, c;
    logic was_on;
    grp = a & 8'hE0;
    if (a == ADDR_WAVE_EN) begin
      wave_en = v[5];
      return;
    end
    if (grp == BANK_CHAR || grp == BANK_LEVEL || grp == BANK_AD || grp == BANK_SR ||
        grp == BANK_WAVE) begin
      off = a & 8'h1F;
      if (off <= 5) s = off;
      else if (off >= 8 && off <= 13) s = off - 2;
      else if (off >= 16 && off <= 21) s = off - 4;
      else return;
      if (SLOT_CH[s] >= NUM_CHANNELS) return;
      case (grp)
        BANK_CHAR: begin
          o_eg[s] = v[5];
          o_mul[s] = v[3:0];
          refresh_phase(SLOT_CH[s]);
        end
        BANK_LEVEL: o_tl[s] = v[5:0];
        BANK_AD: begin
          o_ar[s] = v[7:4];
          o_dr[s] = v[3:0];
          refresh_env(s);
        end
        BANK_SR: begin
          o_sl[s] = v[7:4];
          o_rr[s] = v[3:0];
          refresh_env(s);
        end
        default: o_ws[s] = wave_en ? v[1:0] : 2'd0;
      endcase
      return;
    end
    c = a & 8'h0F;
    if (c >= 9 || c >= NUM_CHANNELS) return;
    case (a & 8'hF0)
      REG_FNUM: begin
        c_fnum[c][7:0] = v;
        refresh_phase(c);
      end
      REG_KEY: begin
        was_on = c_key[c];
        c_key[c] = v[5];
        c_blk[c] = v[4:2];
        c_fnum[c][9:8] = v[1:0];
        refresh_phase(c);
        for (int k = 0; k < 2; k++) begin
          s = CH_MOD[c] + 3 * k;
          if (!was_on && c_key[c]) begin
            ph[s] = '0; est[s] = ENV_ATTACK; lvl[s] = 0; last_out[s] = 0;
          end else if (was_on && !c_key[c] && est[s] != ENV_IDLE) begin
            est[s] = ENV_RELEASE;
          end
        end
      end
      REG_FBCON: begin
        c_fb[c] = v[3:1];
        c_con[c] = v[0];
      end
      default: ;
    endcase
  endtask

  function automatic int wave_at(input logic [31:0] p, input int mod_in, input logic [1:0] w);
    int sh, idx;
    sh  = mod_in >>> 5;
    idx = (int'(p >> 22) + sh) & 1023;
    case (w)
      2'd0: return sine_tbl[idx];
      2'd1: return idx < 512 ? sine_tbl[idx] : 0;
      2'd2: return idx < 512 ? sine_tbl[idx] : sine_tbl[1023 - idx];
      default: return (idx & 256) ? 0 : sine_tbl[(idx & 255) * 2];
    endcase
  endfunction

  function automatic int advance_env(input int s);
    case (est[s])
      ENV_ATTACK: begin
        if (atk[s] >= FS) lvl[s] = FS;
        else lvl[s] += atk[s];
        if (lvl[s] >= FS) begin
          lvl[s] = FS;
          est[s] = ENV_DECAY;
        end
      end
      ENV_DECAY: begin
        if (dcy[s] == 0) est[s] = ENV_SUSTAIN;
        else begin
          lvl[s] -= dcy[s];
          if (lvl[s] <= sus[s]) begin
            lvl[s] = sus[s];
            est[s] = o_eg[s] ? ENV_SUSTAIN : ENV_RELEASE;
          end
        end
      end
      ENV_RELEASE: begin
        if (rel[s] != 0) begin
          lvl[s] -= rel[s];
          if (lvl[s] <= 0) begin
            lvl[s] = 0;
            est[s] = ENV_IDLE;
          end
        end
      end
      default: ;
    endcase
    return lvl[s];
  endfunction

  function automatic int channel_out(input int c);
    int m, k, env, raw, mod_out, car_out, fb_in, sum;
    m = CH_MOD[c];
    k = m + 3;
    if (est[m] == ENV_IDLE && est[k] == ENV_IDLE) return 0;
    env = advance_env(m);
    fb_in = (c_fb[c] != 0) ? (last_out[m] >>> (9 - c_fb[c])) : 0;
    raw = wave_at(ph[m], fb_in, o_ws[m]);
    ph[m] += ph_step[m];
    mod_out = (raw * env / FS) * tl_amp(o_tl[m]) / FS;
    last_out[m] = mod_out;
    env = advance_env(k);
    raw = wave_at(ph[k], c_con[c] ? 0 : mod_out, o_ws[k]);
    ph[k] += ph_step[k];
    car_out = (raw * env / FS) * tl_amp(o_tl[k]) / FS;
    if (!c_con[c]) return car_out;
    sum = car_out + mod_out;
    if (sum > FS) sum = FS;
    if (sum < -FS) sum = -FS;
    return sum;
  endfunction

  function automatic int mix_tick();
    int sum;
    sum = 0;
    for (int c = 0; c < NUM_CHANNELS && c < 9; c++) sum += channel_out(c);
    sum = sum / 4;
    if (sum > FS) sum = FS;
    if (sum < -FS) sum = -FS;
    return sum;
  endfunction

  initial begin
    fail_count = 0;
    samples_owed = 0;
    shadow_reset();
  end

  always @(posedge clk) begin
    int want;
    if (rst) begin
      shadow_reset();
      owed_samples.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_samples.size() == 0) begin
          report("unexpected sample", sample, 0);
        end else begin
          want = owed_samples.pop_front();
          if (sample !== 16'(want)) report("sample", sample, want);
        end
      end
      if (cfg_we) rate = cfg_wdata;
      if (in_valid && in_ready) begin
        if (mode) owed_samples.push_back(mix_tick());
        else apply_write(reg_addr, reg_value);
      end
    end
    samples_owed = owed_samples.size();
  end

endmodule

@@ dv/fm_synth_register_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_synth_register_engine_tb
// Drives register and tick words into the fm synth engine under several
// sample rates and idle patterns; the checker grades every sample word.
// ----------------------------------------------------------------------------
module fm_synth_register_engine_tb;
  import fmse_pkg::*;

  localparam logic       MODE_WRITE = 1'b0;
  localparam logic       MODE_TICK  = 1'b1;
  localparam logic [7:0] BANK_CHAR  = 8'h20;
  localparam logic [7:0] BANK_LEVEL = 8'h40;
  localparam logic [7:0] BANK_AD    = 8'h60;
  localparam logic [7:0] BANK_SR    = 8'h80;
  localparam logic [7:0] BANK_WAVE  = 8'hE0;
  localparam logic [7:0] REG_FNUM   = 8'hA0;
  localparam logic [7:0] REG_KEY    = 8'hB0;
  localparam logic [7:0] REG_FBCON  = 8'hC0;
  localparam int         DRAIN      = 800;
  localparam int         WORDS      = 1250;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = MODE_WRITE;
  logic [7:0]         reg_addr = '0;
  logic [7:0]         reg_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] sample;
  logic               cfg_we = 1'b0;
  logic [16:0]        cfg_wdata = '0;
  int                 fail_count;
  int                 samples_owed;

  int src_idle = 0;
  int dst_idle = 0;
  logic hold_off = 1'b0;
  int words_sent = 0;
  int ticks_sent = 0;
  int rate_count = 0;

  always #2 clk = ~clk;

  fm_synth_register_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .reg_addr(reg_addr), .reg_value(reg_value),
    .out_valid(out_valid), .out_ready(out_ready), .sample(sample),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  fm_synth_register_engine_chk chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .reg_addr(reg_addr), .reg_value(reg_value),
    .out_valid(out_valid), .out_ready(out_ready), .sample(sample),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .samples_owed(samples_owed)
  );

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= dst_idle);
  end

  task automatic send_word(input logic m, input logic [7:0] a, input logic [7:0] v);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    reg_addr  <= a;
    reg_value <= v;
    // ready is stable by the falling edge, so the word goes at the next rise
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    words_sent++;
    if (m == MODE_TICK) ticks_sent++;
  endtask

  task automatic write_reg(input logic [7:0] a, input logic [7:0] v);
    send_word(MODE_WRITE, a, v);
  endtask

  task automatic ticks(input int n);
    for (int i = 0; i < n; i++) send_word(MODE_TICK, 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] op_offset(input int c, input int carrier);
    return 8'((c / 3) * 8 + (c % 3) + (carrier ? 3 : 0));
  endfunction

  // full voice setup with random content, then a key-on write, sometimes after a key-off write
  task automatic voice_up(input int c);
    for (int k = 0; k < 2; k++) begin
      write_reg(BANK_CHAR | op_offset(c, k), 8'($urandom));
      write_reg(BANK_LEVEL | op_offset(c, k), 8'($urandom_range(40)) | 8'($urandom) & 8'hC0);
      write_reg(BANK_AD | op_offset(c, k), 8'($urandom));
      write_reg(BANK_SR | op_offset(c, k), 8'($urandom));
      write_reg(BANK_WAVE | op_offset(c, k), 8'($urandom));
    end
    write_reg(REG_FNUM | 8'(c), 8'($urandom));
    write_reg(REG_FBCON | 8'(c), 8'($urandom));
    if ($urandom_range(1)) write_reg(REG_KEY | 8'(c), 8'($urandom) & 8'hDF);
    write_reg(REG_KEY | 8'(c), 8'($urandom) | 8'h20);
  endtask

  task automatic set_rate(input logic [16:0] r);
    in_valid <= 1'b0;
    wait (samples_owed == 0);
    // register writes leave no word behind, so give the queue time to empty
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_count++;
  endtask

  task automatic directed_words();
    write_reg(ADDR_WAVE_EN, 8'h20);
    write_reg(BANK_CHAR, 8'h2F);
    write_reg(BANK_LEVEL, 8'h00);
    write_reg(BANK_AD, 8'hFF);
    write_reg(BANK_SR, 8'hFF);
    write_reg(BANK_WAVE, 8'hE3);
    write_reg(BANK_WAVE | 8'h03, 8'h02);
    write_reg(BANK_LEVEL | 8'h03, 8'h3F);
    write_reg(REG_FNUM, 8'hFF);
    write_reg(REG_FBCON, 8'h0F);
    write_reg(REG_KEY, 8'h3F);
    ticks(2);
    write_reg(REG_FBCON | 8'h08, 8'h0E);
    write_reg(REG_KEY | 8'h08, 8'h20);
    write_reg(ADDR_WAVE_EN, 8'h00);
    write_reg(BANK_WAVE | 8'h15, 8'h03);
    write_reg(BANK_CHAR | 8'h06, 8'h0F);
    write_reg(REG_FNUM | 8'h09, 8'hFF);
    write_reg(8'hFF, 8'hFF);
    ticks(1);
    write_reg(REG_KEY, 8'h1F);
    send_word(MODE_TICK, 8'hFF, 8'hFF);
    send_word(MODE_TICK, 8'h00, 8'h00);
  endtask

  task automatic random_words(input int quota);
    int stop_at, pick;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        if ($urandom_range(3) == 0) write_reg(ADDR_WAVE_EN, 8'($urandom));
        voice_up($urandom_range(8));
        ticks($urandom_range(8, 1));
      end else if (pick < 70) begin
        ticks($urandom_range(6, 1));
      end else if (pick < 82) begin
        write_reg(REG_KEY | 8'($urandom_range(8)), 8'($urandom) & 8'hDF);
        ticks($urandom_range(4, 1));
      end else begin
        send_word(1'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [16:0] rates [6];
    rates = '{17'd44100, 17'd0, 17'h1FFFF, 17'd4000, 17'd96000, 17'd44100};
    rates[5] = 17'($urandom_range(96000, 4000));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      src_idle = (p < 2) ? 22 : (p < 4) ? 59 : 0;
      dst_idle = (p < 2) ? 59 : (p < 4) ? 22 : 0;
      set_rate(rates[p]);
      if (p == 1) begin
        fork
          begin
            @(negedge clk);
            hold_off = 1'b1;
            repeat (1500) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (p == 0) directed_words();
      random_words(WORDS / 6);
    end
    in_valid <= 1'b0;
    wait (samples_owed == 0);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d words (%0d ticks) over %0d sample rate settings,", words_sent,
             ticks_sent, rate_count);
    $display("including zero and full-width rates and a long output stall");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout after %0d words", words_sent);
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/fmse_pkg.sv
rtl/core/fmse_front.sv
rtl/core/fmse_div.sv
rtl/core/fmse_back.sv
rtl/core/fm_synth_register_engine.sv
dv/fm_synth_register_engine_chk.sv
dv/fm_synth_register_engine_tb.sv
